### src/bdps_pkg.sv
// Shared types and constants of the bus device poll supervisor.
`default_nettype none

package bdps_pkg;

   // Default slot counts of the two device classes.
   localparam int DEF_CLASS0_SLOTS = 8;
   localparam int DEF_CLASS1_SLOTS = 8;

   // Device numbers and rotation indexes are carried in this many bits (slots up to 16).
   localparam int NUM_W = 5;

   // Request kinds carried in req_tuser.
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_REPLY = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // Register word indexes on the configuration port.
   localparam logic [1:0] REG_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_LIMIT   = 2'd1;
   localparam logic [1:0] REG_COUNT0  = 2'd2;
   localparam logic [1:0] REG_COUNT1  = 2'd3;

   // Reset values of the registers.
   localparam logic [15:0] TIMEOUT_RESET = 16'd200;
   localparam logic [7:0]  LIMIT_RESET   = 8'd3;
   localparam logic [3:0]  COUNT_RESET   = 4'd8;

   // Last step of the schedule counter.
   localparam logic [2:0] SCHED_LAST = 3'd6;

   // Command from the item logic to one device class.
   typedef struct packed {
      logic        reply;    // valid reply from device num
      logic        timeout;  // polled device of this class missed its reply
      logic        poll;     // this class is polled by the item
      logic [3:0]  num;      // device number of a reply or a status read
      logic [15:0] version;  // version carried by a reply
   } bdps_cmd_type;

   // Status returned by one device class.
   typedef struct packed {
      logic             in_range;      // num lies in 1..effective count
      logic [NUM_W-1:0] next_idx;      // device that a poll of this class selects
      logic [15:0]      rd_version;    // stored version of device num
      logic [7:0]       rd_misses;     // stored miss count of device num
      logic             fault_raised;  // the timeout pushed the device over the limit
      logic [7:0]       fault_map;     // fault bits after the item
   } bdps_stat_type;

endpackage

`default_nettype wire

### src/bdps_group.sv
// Per-class device table: rotation index, miss counts, versions and fault bits.
`default_nettype none

module bdps_group
   import bdps_pkg::*;
#(
   parameter int SLOTS = DEF_CLASS0_SLOTS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [3:0]    count_reg,
   input  wire logic [7:0]    miss_limit,
   input  wire bdps_cmd_type  cmd,
   output      bdps_stat_type stat
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [NUM_W-1:0] SLOTS_N = NUM_W'(SLOTS);

   logic [NUM_W-1:0] index_ff, index_in;
   logic [7:0]       misses_ff [SLOTS];
   logic [15:0]      versions_ff [SLOTS];
   logic [7:0]       faults_ff, faults_in;

   logic [NUM_W-1:0] eff_count;
   logic [NUM_W-1:0] count_n;
   logic [NUM_W-1:0] num_n;
   logic [NUM_W-1:0] addr_n;
   logic [NUM_W-1:0] addr_m1;
   logic [SLOT_W-1:0] slot;
   logic [NUM_W-1:0] idx_inc;
   logic             hit;
   logic [7:0]       miss_cur, miss_inc;
   logic             over;
   logic             has_bit;

   always_comb begin
      count_n = {1'b0, count_reg};
      if (count_n == '0) begin
         eff_count = NUM_W'(1);
      end else if (count_n > SLOTS_N) begin
         eff_count = SLOTS_N;
      end else begin
         eff_count = count_n;
      end
   end

   // A timeout addresses the polled device, everything else the requested one.
   assign num_n   = {1'b0, cmd.num};
   assign addr_n  = cmd.timeout ? index_ff : num_n;
   assign addr_m1 = addr_n - NUM_W'(1);
   assign slot    = addr_m1[SLOT_W-1:0];
   assign has_bit = (addr_n != '0) && (addr_m1 < NUM_W'(8));

   assign hit      = cmd.timeout && (index_ff != '0) && (index_ff <= SLOTS_N);
   assign miss_cur = misses_ff[slot];
   assign miss_inc = (miss_cur == 8'hFF) ? miss_cur : miss_cur + 8'd1;
   assign over     = miss_inc > miss_limit;

   assign idx_inc = index_ff + NUM_W'(1);

   always_comb begin
      index_in  = index_ff;
      faults_in = faults_ff;
      if (cmd.poll) begin
         index_in = (idx_inc > eff_count) ? NUM_W'(1) : idx_inc;
      end
      if (has_bit) begin
         if (cmd.reply) begin
            faults_in[addr_m1[2:0]] = 1'b0;
         end else if (hit && over) begin
            faults_in[addr_m1[2:0]] = 1'b1;
         end
      end
   end

   assign stat.in_range     = (num_n != '0) && (num_n <= eff_count);
   assign stat.next_idx     = index_in;
   assign stat.rd_version   = versions_ff[slot];
   assign stat.rd_misses    = miss_cur;
   assign stat.fault_raised = hit && over;
   assign stat.fault_map    = faults_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff  <= '0;
         faults_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            misses_ff[i]   <= '0;
            versions_ff[i] <= '0;
         end
      end else if (accept) begin
         index_ff  <= index_in;
         faults_ff <= faults_in;
         if (cmd.reply) begin
            versions_ff[slot] <= cmd.version;
            misses_ff[slot]   <= '0;
         end else if (hit) begin
            misses_ff[slot] <= miss_inc;
            if (over) begin
               versions_ff[slot] <= '0;
            end
         end
      end
   end

endmodule

`default_nettype wire

### src/bus_device_poll_supervisor.sv
// Top level of the bus device poll supervisor: item logic, schedule, token and registers.
// A result appears in the cycle after its item is accepted, from the result register.
// Throughput: one item per cycle while results are taken; the whole item is settled by the logic in front of the
// result register, and the result register frees itself in the cycle its item is taken.
// Reset: synchronous and active high; the token is held, timers, schedule, indexes,
// miss counts, versions and fault bits are cleared, and the registers take their defaults.
`default_nettype none

module bus_device_poll_supervisor
   import bdps_pkg::*;
#(
   parameter int CLASS0_SLOTS = DEF_CLASS0_SLOTS,
   parameter int CLASS1_SLOTS = DEF_CLASS1_SLOTS
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // Request items.
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // Bits from 0: device_class(1), device_number(4), version_high(8), version_low(8), pad(3).
   input  wire logic [23:0] req_tdata,
   // Bits from 0: req_type(2).
   input  wire logic [1:0]  req_tuser,

   // Result items.
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // Bits from 0: poll_issued(1), poll_class(1), poll_number(4), fault_raised(1),
   // reply_rejected(1), class0_fault_map(8), class1_fault_map(8), read_version(16),
   // read_misses(8).
   output      logic [47:0] rsp_tdata,

   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   // Configuration registers.
   logic [15:0] timeout_ff;
   logic [7:0]  limit_ff;
   logic [3:0]  count0_ff;
   logic [3:0]  count1_ff;

   // Supervisor state.
   logic        token_ff, token_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [2:0]  step_ff, step_in;
   logic        polled_class_ff, polled_class_in;

   // Result register.
   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff, rsp_data_in;

   // Request fields.
   logic        device_class;
   logic [3:0]  device_number;
   logic [7:0]  version_high;
   logic [7:0]  version_low;
   logic [1:0]  req_type;

   logic          accept;
   logic          csr_write;
   bdps_cmd_type  cmd0, cmd1;
   bdps_stat_type stat0, stat1;

   logic        valid_num;
   logic        is_tick, is_reply, is_read;
   logic [15:0] elapsed_inc;
   logic        timeout;
   logic        reply_ok;
   logic        token_mid;
   logic        poll_class;
   logic [3:0]  poll_number;
   logic        rejected;
   logic        fault_raised;
   logic [15:0] read_version;
   logic [7:0]  read_misses;

   assign device_class  = req_tdata[0];
   assign device_number = req_tdata[4:1];
   assign version_high  = req_tdata[12:5];
   assign version_low   = req_tdata[20:13];
   assign req_type      = req_tuser;

   // The result register is free when empty or when its item leaves in this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Configuration port: always ready, written in the access phase.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         limit_ff   <= LIMIT_RESET;
         count0_ff  <= COUNT_RESET;
         count1_ff  <= COUNT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_TIMEOUT: timeout_ff <= csr_pwdata[15:0];
            REG_LIMIT:   limit_ff   <= csr_pwdata[7:0];
            REG_COUNT0:  count0_ff  <= csr_pwdata[3:0];
            REG_COUNT1:  count1_ff  <= csr_pwdata[3:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_TIMEOUT: csr_prdata = {16'd0, timeout_ff};
         REG_LIMIT:   csr_prdata = {24'd0, limit_ff};
         REG_COUNT0:  csr_prdata = {28'd0, count0_ff};
         REG_COUNT1:  csr_prdata = {28'd0, count1_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Item logic. The request is handled first; if the token is then held,
   // the next device in the schedule is polled and the token goes out again.
   // ------------------------------------------------------------------
   always_comb begin
      is_tick  = 1'b0;
      is_reply = 1'b0;
      is_read  = 1'b0;
      case (req_type)
         REQ_TICK:  is_tick  = 1'b1;
         REQ_REPLY: is_reply = 1'b1;
         REQ_READ:  is_read  = 1'b1;
         default:   ;
      endcase
   end

   assign valid_num = device_class ? stat1.in_range : stat0.in_range;

   // The tick counter saturates, and the timeout test sees the incremented count.
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign timeout     = is_tick && !token_ff && (elapsed_inc > timeout_ff);
   assign reply_ok    = is_reply && valid_num;
   assign token_mid   = token_ff || timeout || reply_ok;
   assign rejected    = (is_reply || is_read) && !valid_num;

   // Odd schedule steps poll class 0, even steps class 1.
   assign poll_class = !step_ff[0];

   always_comb begin
      cmd0.reply   = reply_ok && !device_class;
      cmd0.timeout = timeout && !polled_class_ff;
      cmd0.poll    = token_mid && !poll_class;
      cmd0.num     = device_number;
      cmd0.version = {version_high, version_low};

      cmd1.reply   = reply_ok && device_class;
      cmd1.timeout = timeout && polled_class_ff;
      cmd1.poll    = token_mid && poll_class;
      cmd1.num     = device_number;
      cmd1.version = {version_high, version_low};
   end

   bdps_group #(
      .SLOTS (CLASS0_SLOTS)
   ) u_group0 (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .count_reg  (count0_ff),
      .miss_limit (limit_ff),
      .cmd        (cmd0),
      .stat       (stat0)
   );

   bdps_group #(
      .SLOTS (CLASS1_SLOTS)
   ) u_group1 (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .count_reg  (count1_ff),
      .miss_limit (limit_ff),
      .cmd        (cmd1),
      .stat       (stat1)
   );

   assign poll_number  = poll_class ? stat1.next_idx[3:0] : stat0.next_idx[3:0];
   assign fault_raised = stat0.fault_raised || stat1.fault_raised;

   // Status reads report only for an in-range device.
   always_comb begin
      read_version = '0;
      read_misses  = '0;
      if (is_read && valid_num) begin
         read_version = device_class ? stat1.rd_version : stat0.rd_version;
         read_misses  = device_class ? stat1.rd_misses : stat0.rd_misses;
      end
   end

   // Next supervisor state. A poll releases the token and restarts the timer.
   always_comb begin
      token_in        = token_mid;
      elapsed_in      = is_tick ? elapsed_inc : elapsed_ff;
      step_in         = step_ff;
      polled_class_in = polled_class_ff;
      if (token_mid) begin
         token_in        = 1'b0;
         elapsed_in      = '0;
         step_in         = (step_ff >= SCHED_LAST) ? 3'd0 : step_ff + 3'd1;
         polled_class_in = poll_class;
      end
   end

   always_comb begin
      rsp_data_in = {read_misses,
                     read_version,
                     stat1.fault_map,
                     stat0.fault_map,
                     rejected,
                     fault_raised,
                     token_mid ? poll_number : 4'd0,
                     token_mid ? poll_class : 1'b0,
                     token_mid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff        <= 1'b1;
         elapsed_ff      <= '0;
         step_ff         <= '0;
         polled_class_ff <= 1'b0;
      end else if (accept) begin
         token_ff        <= token_in;
         elapsed_ff      <= elapsed_in;
         step_ff         <= step_in;
         polled_class_ff <= polled_class_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire
